[rtl/b64pcm_pkg.sv]
// Package with the request and response types and the base64 alphabet lookup.
`timescale 1ns / 1ps

package b64pcm_pkg;

   localparam int CharWidth   = 8;
   localparam int SextetWidth = 6;
   localparam int SampleWidth = 16;
   localparam int ByteWidth   = 8;
   localparam int CountWidth  = 3;

   localparam logic [SextetWidth-1:0] SextetPlus  = 6'd62;
   localparam logic [SextetWidth-1:0] SextetSlash = 6'd63;

   typedef struct packed {
      logic [CharWidth-1:0] char_code;
      logic                 end_of_text;
   } req_type;

   typedef struct packed {
      logic signed [SampleWidth-1:0] sample;
      logic                          from_last_char;
   } rsp_type;

   typedef struct packed {
      logic                   valid;
      logic [SextetWidth-1:0] value;
   } sextet_type;

   // Maps one character to its alphabet value; characters outside the alphabet are invalid.
   function automatic sextet_type sextet_of(input logic [CharWidth-1:0] c);
      sextet_type s;
      s.valid = 1'b1;
      s.value = '0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         s.value = SextetWidth'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         s.value = SextetWidth'(c - 8'h47);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         s.value = SextetWidth'(c + 8'h04);
      end else if (c == 8'h2B) begin
         s.value = SextetPlus;
      end else if (c == 8'h2F) begin
         s.value = SextetSlash;
      end else begin
         s.valid = 1'b0;
      end
      return s;
   endfunction

endpackage

[rtl/b64pcm_unpack.sv]
// Bit accumulator, byte forming and little-endian sample pairing.
`timescale 1ns / 1ps

module b64pcm_unpack
   import b64pcm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type item,
   output logic    produced,
   output rsp_type result
);

   logic [SextetWidth-1:0] residual_ff, residual_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic [ByteWidth-1:0]   low_byte_ff, low_byte_in;
   logic                   have_low_ff, have_low_in;

   sextet_type                  sx;
   logic [CountWidth:0]         cnt_sum;
   logic [2*SextetWidth-1:0]    acc;
   logic                        full;
   logic [CountWidth-1:0]       rest;
   logic [ByteWidth-1:0]        new_byte;
   logic [SextetWidth-1:0]      rest_mask;

   always_comb begin
      sx        = sextet_of(item.char_code);
      cnt_sum   = {1'b0, count_ff} + (CountWidth+1)'(SextetWidth);
      acc       = {residual_ff, sx.value};
      full      = cnt_sum[CountWidth];
      rest      = cnt_sum[CountWidth-1:0];
      new_byte  = ByteWidth'(acc >> rest);
      rest_mask = (SextetWidth'(1) << rest) - SextetWidth'(1);

      residual_in = residual_ff;
      count_in    = count_ff;
      low_byte_in = low_byte_ff;
      have_low_in = have_low_ff;
      produced    = 1'b0;

      if (sx.valid) begin
         if (full) begin
            residual_in = acc[SextetWidth-1:0] & rest_mask;
            count_in    = rest;
            if (have_low_ff) begin
               produced    = 1'b1;
               have_low_in = 1'b0;
               low_byte_in = '0;
            end else begin
               low_byte_in = new_byte;
               have_low_in = 1'b1;
            end
         end else begin
            residual_in = acc[SextetWidth-1:0];
            count_in    = rest;
         end
      end

      if (item.end_of_text) begin
         residual_in = '0;
         count_in    = '0;
         low_byte_in = '0;
         have_low_in = 1'b0;
      end

      produced              = produced & step;
      result.sample         = {new_byte, low_byte_ff};
      result.from_last_char = item.end_of_text;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         residual_ff <= '0;
         count_ff    <= '0;
         low_byte_ff <= '0;
         have_low_ff <= 1'b0;
      end else if (step) begin
         residual_ff <= residual_in;
         count_ff    <= count_in;
         low_byte_ff <= low_byte_in;
         have_low_ff <= have_low_in;
      end
   end

endmodule

[rtl/base64_to_pcm16_decoder.sv]
// Top level: request register, base64 unpacking and response register.
// Throughput: one request per cycle while the response is not stalled; the
// request register feeds the decode and pairing logic, which writes the
// response register in the same cycle.
// Reset is synchronous and active high; it clears all decode state and
// empties both the request and response registers.
`timescale 1ns / 1ps

module base64_to_pcm16_decoder
   import b64pcm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic    req_valid_ff;
   req_type req_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   logic    out_free;
   logic    step;
   logic    produced;
   rsp_type result;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = req_valid_ff && out_free;
   assign req_stall = req_valid_ff && !out_free;

   b64pcm_unpack u_unpack (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .item     (req_ff),
      .produced (produced),
      .result   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            req_valid_ff <= req_valid;
         end
         if (out_free) begin
            rsp_valid_ff <= produced;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         req_ff <= req_payload;
      end
      if (out_free && produced) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[rtl/b64pcm_checker.sv]
// Port-level assertions for the decoder and the bind that attaches them.
`timescale 1ns / 1ps

module b64pcm_checker
   import b64pcm_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("Stalled response was dropped or changed.");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_payload))
      else $error("Stalled request was dropped or changed.");

   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("Request stalled while the response register is empty.");

   a_reset_empties: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("Response or stall present right after reset.");

   a_stall_needs_rsp_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("Request stalled without a stalled response.");

endmodule

bind base64_to_pcm16_decoder b64pcm_checker u_b64pcm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
